// ===== sv/cfla_pkg.sv =====
// Shared types, constants and helpers for the chunked free-list allocator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package cfla_pkg;

  // Default chunk count and the block limit per chunk
  localparam int unsigned MAX_CHUNKS   = 16;
  localparam int unsigned BLK_W        = 8;
  localparam logic [BLK_W-1:0] MAX_BLOCKS = 8'd255;

  // Register widths, reset values and APB geometry
  localparam int unsigned REG_CHUNKS_W = 5;
  localparam int unsigned NC_W         = 9;   // holds any chunk count up to 256
  localparam int unsigned APB_AW       = 3;
  localparam int unsigned APB_DW       = 32;
  localparam logic [BLK_W-1:0]        BLOCKS_RST = 8'd255;
  localparam logic [REG_CHUNKS_W-1:0] CHUNKS_RST = 5'd16;

  typedef enum logic {
    REG_BLOCKS = 1'b0,
    REG_CHUNKS = 1'b1
  } reg_idx_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NO_SPACE = 2'd1,
    ST_RANGE    = 2'd2
  } status_e;

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } fsm_e;

  // Write-back of one chunk's head and free count
  typedef struct packed {
    logic             en;
    logic [BLK_W-1:0] head;
    logic [BLK_W-1:0] count;
  } chunk_upd_t;

  // Register file contents plus the re-init pulse
  typedef struct packed {
    logic [BLK_W-1:0]        blocks;
    logic [REG_CHUNKS_W-1:0] chunks;
    logic                    init;
  } cfg_t;

  // Blocks per chunk clamped to 1..MAX_BLOCKS
  function automatic logic [BLK_W-1:0] eff_blocks(input logic [BLK_W-1:0] b);
    logic [BLK_W-1:0] r;
    if (b == '0) begin
      r = 8'd1;
    end else if (b > MAX_BLOCKS) begin
      r = MAX_BLOCKS;
    end else begin
      r = b;
    end
    return r;
  endfunction

endpackage

// ===== sv/cfla_cfg.sv =====
// APB register file: blocks_per_chunk and chunks_in_use.
// Depends on cfla_pkg; a write to either register raises the re-init pulse.
`timescale 1ns / 1ps

module cfla_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfla_pkg::APB_AW-1:0]   paddr,
  input  logic [cfla_pkg::APB_DW-1:0]   pwdata,
  output logic [cfla_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output cfla_pkg::cfg_t                cfg_o
);
  import cfla_pkg::*;

  logic [BLK_W-1:0]        blocks_q;
  logic [REG_CHUNKS_W-1:0] chunks_q;
  logic                    wr_beat;
  reg_idx_e                idx;

  assign pready  = 1'b1;
  assign wr_beat = psel & penable & pwrite & pready;
  assign idx     = reg_idx_e'(paddr[APB_AW-1]);

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blocks_q <= BLOCKS_RST;
      chunks_q <= CHUNKS_RST;
    end else if (wr_beat) begin
      case (idx)
        REG_BLOCKS: blocks_q <= pwdata[BLK_W-1:0];
        REG_CHUNKS: chunks_q <= pwdata[REG_CHUNKS_W-1:0];
        default:    blocks_q <= blocks_q;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      REG_BLOCKS: prdata = {{(APB_DW-BLK_W){1'b0}}, blocks_q};
      REG_CHUNKS: prdata = {{(APB_DW-REG_CHUNKS_W){1'b0}}, chunks_q};
      default:    prdata = '0;
    endcase
  end

  assign cfg_o.blocks = blocks_q;
  assign cfg_o.chunks = chunks_q;
  assign cfg_o.init   = wr_beat;

endmodule

// ===== sv/cfla_link_ram.sv =====
// Link memory: one next-free entry per block of every chunk, registered read.
// Depends on cfla_pkg. Holds its own clearing sweep after reset and re-init.
`timescale 1ns / 1ps

module cfla_link_ram #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Aw    = 12
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          init_i,
  input  logic                          re_i,
  input  logic [Aw-1:0]                 raddr_i,
  input  logic                          we_i,
  input  logic [Aw-1:0]                 waddr_i,
  input  logic [cfla_pkg::BLK_W-1:0]    wdata_i,
  output logic [cfla_pkg::BLK_W-1:0]    rdata_o,
  output logic                          clearing_o
);
  import cfla_pkg::*;

  logic [BLK_W-1:0] mem_q [Depth];
  logic [BLK_W-1:0] rdata_q;
  logic [Aw-1:0]    clr_addr_q;
  logic             clr_q;
  logic             wr_en;
  logic [Aw-1:0]    wr_addr;
  logic [BLK_W-1:0] wr_data;

  // Clearing sweep: entry for block b gets b+1 (mod 256)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (init_i) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == Aw'(Depth - 1)) begin
        clr_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + Aw'(1);
      end
    end
  end

  // Sweep owns the write port while it runs
  assign wr_en   = clr_q | we_i;
  assign wr_addr = clr_q ? clr_addr_q : waddr_i;
  assign wr_data = clr_q ? (clr_addr_q[BLK_W-1:0] + 8'd1) : wdata_i;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o    = rdata_q;
  assign clearing_o = clr_q;

endmodule

// ===== sv/cfla_chunk_tbl.sv =====
// Per-chunk head and free count, with valid bits standing in for reset values.
// Depends on cfla_pkg; exposes one read port and the nonzero-count vector.
`timescale 1ns / 1ps

module cfla_chunk_tbl #(
  parameter int unsigned MaxChunks = 16,
  parameter int unsigned ChunkW    = 4
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          init_i,
  input  logic [cfla_pkg::BLK_W-1:0]    eff_blocks_i,
  input  logic [ChunkW-1:0]             rd_idx_i,
  output logic [cfla_pkg::BLK_W-1:0]    rd_head_o,
  output logic [cfla_pkg::BLK_W-1:0]    rd_cnt_o,
  output logic [MaxChunks-1:0]          nz_o,
  input  logic [ChunkW-1:0]             wr_idx_i,
  input  cfla_pkg::chunk_upd_t          upd_i
);
  import cfla_pkg::*;

  logic [BLK_W-1:0]     head_q [MaxChunks];
  logic [BLK_W-1:0]     cnt_q  [MaxChunks];
  logic [MaxChunks-1:0] vld_q;
  logic [BLK_W-1:0]     eff_head [MaxChunks];
  logic [BLK_W-1:0]     eff_cnt  [MaxChunks];

  // Valid bits: cleared at reset and re-init, set on first write-back
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (init_i) begin
      vld_q <= '0;
    end else begin
      for (int i = 0; i < MaxChunks; i++) begin
        if (upd_i.en && wr_idx_i == ChunkW'(i)) begin
          vld_q[i] <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MaxChunks; i++) begin
      if (upd_i.en && wr_idx_i == ChunkW'(i)) begin
        head_q[i] <= upd_i.head;
        cnt_q[i]  <= upd_i.count;
      end
    end
  end

  // Unwritten entries read as head 0, count blocks_per_chunk
  always_comb begin
    for (int i = 0; i < MaxChunks; i++) begin
      eff_head[i] = vld_q[i] ? head_q[i] : '0;
      eff_cnt[i]  = vld_q[i] ? cnt_q[i]  : eff_blocks_i;
      nz_o[i]     = (eff_cnt[i] != '0);
    end
  end

  // Read port
  always_comb begin
    rd_head_o = '0;
    rd_cnt_o  = '0;
    for (int i = 0; i < MaxChunks; i++) begin
      if (rd_idx_i == ChunkW'(i)) begin
        rd_head_o = eff_head[i];
        rd_cnt_o  = eff_cnt[i];
      end
    end
  end

endmodule

// ===== sv/chunked_free_list_allocator.sv =====
// Chunked free-list block allocator, top level. Uses cfla_pkg, cfla_cfg,
// cfla_chunk_tbl and cfla_link_ram.
//
// Commands: drive op_i (allocate or free), chunk_index_i and block_index_i
// with start; the beat is taken at an edge where start is high and busy low.
// Each command returns exactly one result beat: done_o is high for one cycle
// with status_o, granted_chunk_o, granted_block_o and free_left_o.
// The accepting edge moves the sequencer to its execute state, and done_o is
// registered from that state. A new command is not taken while one is in
// its execute state. The accept cycle reads the chunk table and issues the
// link-memory read; the next cycle writes link memory and chunk table back.
// busy drops again as the result is shown.
// The receiver cannot stall: every result beat is taken as it is shown.
// Reset, and every register write over APB, starts a clearing pass over all
// MaxChunks*256 entries of the link memory (4096 by default); busy is high for
// its whole length. Register writes are only legal while no command is in flight.
`timescale 1ns / 1ps

module chunked_free_list_allocator #(
  parameter  int unsigned MaxChunks = cfla_pkg::MAX_CHUNKS,
  localparam int unsigned ChunkW    = (MaxChunks > 1) ? $clog2(MaxChunks) : 1
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // command beat
  input  logic                          start,
  output logic                          busy,
  input  logic                          op_i,
  input  logic [ChunkW-1:0]             chunk_index_i,
  input  logic [cfla_pkg::BLK_W-1:0]    block_index_i,
  // result beat
  output logic                          done_o,
  output logic [1:0]                    status_o,
  output logic [ChunkW-1:0]             granted_chunk_o,
  output logic [cfla_pkg::BLK_W-1:0]    granted_block_o,
  output logic [cfla_pkg::BLK_W-1:0]    free_left_o,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cfla_pkg::APB_AW-1:0]   paddr,
  input  logic [cfla_pkg::APB_DW-1:0]   pwdata,
  output logic [cfla_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import cfla_pkg::*;

  localparam int unsigned LinkDepth = MaxChunks * (2 ** BLK_W);
  localparam int unsigned LinkAw    = ChunkW + BLK_W;

  cfg_t                 cfg;
  chunk_upd_t           upd;
  logic                 clearing;
  fsm_e                 state_q, state_d;
  logic                 accept;
  logic [NC_W-1:0]      nc;
  logic [MaxChunks-1:0] in_use;
  logic [MaxChunks-1:0] nz;
  logic [BLK_W-1:0]     blocks_eff;

  // chunk pick
  logic                 any_free;
  logic                 recent_ok;
  logic [ChunkW-1:0]    pick;
  logic [ChunkW-1:0]    sel_chunk;
  logic [ChunkW-1:0]    rd_idx;
  logic [BLK_W-1:0]     rd_head;
  logic [BLK_W-1:0]     rd_cnt;
  logic                 range_ok;
  logic [ChunkW-1:0]    recent_q;
  logic                 recent_vld_q;

  // request held through the execute cycle
  op_e                  op_q;
  status_e              st_q;
  logic [ChunkW-1:0]    chunk_q;
  logic [BLK_W-1:0]     blk_q;
  logic [BLK_W-1:0]     lnk_q;
  logic [BLK_W-1:0]     cnt_q;
  logic                 exec_ok;
  logic [BLK_W-1:0]     cnt_dec;
  logic [BLK_W-1:0]     cnt_inc;
  logic [BLK_W-1:0]     cnt_new;

  // link memory port
  logic                 link_re;
  logic [LinkAw-1:0]    link_raddr;
  logic                 link_we;
  logic [LinkAw-1:0]    link_waddr;
  logic [BLK_W-1:0]     link_rdata;

  // result registers
  logic                 done_q;
  status_e              res_st_q;
  logic [ChunkW-1:0]    res_chunk_q;
  logic [BLK_W-1:0]     res_blk_q;
  logic [BLK_W-1:0]     res_left_q;

  cfla_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign blocks_eff = eff_blocks(cfg.blocks);

  // Effective chunk count, clamped to 1..MaxChunks
  always_comb begin
    if (cfg.chunks == '0) begin
      nc = NC_W'(1);
    end else if (NC_W'(cfg.chunks) > NC_W'(MaxChunks)) begin
      nc = NC_W'(MaxChunks);
    end else begin
      nc = NC_W'(cfg.chunks);
    end
    for (int i = 0; i < MaxChunks; i++) begin
      in_use[i] = (NC_W'(i) < nc);
    end
  end

  cfla_chunk_tbl #(
    .MaxChunks (MaxChunks),
    .ChunkW    (ChunkW)
  ) u_chunk_tbl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .init_i       (cfg.init),
    .eff_blocks_i (blocks_eff),
    .rd_idx_i     (rd_idx),
    .rd_head_o    (rd_head),
    .rd_cnt_o     (rd_cnt),
    .nz_o         (nz),
    .wr_idx_i     (chunk_q),
    .upd_i        (upd)
  );

  cfla_link_ram #(
    .Depth (LinkDepth),
    .Aw    (LinkAw)
  ) u_link_ram (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .init_i     (cfg.init),
    .re_i       (link_re),
    .raddr_i    (link_raddr),
    .we_i       (link_we),
    .waddr_i    (link_waddr),
    .wdata_i    (lnk_q),
    .rdata_o    (link_rdata),
    .clearing_o (clearing)
  );

  assign busy   = (state_q != S_IDLE) | clearing;
  assign accept = start & ~busy;

  // Chunk pick: recent chunk first, else lowest managed chunk with a free block
  always_comb begin
    any_free  = 1'b0;
    recent_ok = 1'b0;
    pick      = '0;
    for (int i = MaxChunks - 1; i >= 0; i--) begin
      if (nz[i] && in_use[i]) begin
        any_free = 1'b1;
        pick     = ChunkW'(i);
      end
    end
    for (int i = 0; i < MaxChunks; i++) begin
      if (recent_vld_q && recent_q == ChunkW'(i) && nz[i] && in_use[i]) begin
        recent_ok = 1'b1;
      end
    end
    sel_chunk = recent_ok ? recent_q : pick;
  end

  assign rd_idx   = (op_i == OP_FREE) ? chunk_index_i : sel_chunk;
  assign range_ok = (NC_W'(chunk_index_i) < nc) && (block_index_i < blocks_eff);

  // Allocation reads the head block's link in the accept cycle
  assign link_re    = accept && (op_i == OP_ALLOC);
  assign link_raddr = {sel_chunk, rd_head};

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q    <= op_e'(op_i);
      chunk_q <= rd_idx;
      blk_q   <= (op_i == OP_ALLOC) ? rd_head : block_index_i;
      lnk_q   <= rd_head;
      cnt_q   <= rd_cnt;
      if (op_i == OP_ALLOC) begin
        st_q <= any_free ? ST_OK : ST_NO_SPACE;
      end else begin
        st_q <= range_ok ? ST_OK : ST_RANGE;
      end
    end
  end

  // Write-back in the execute cycle
  assign exec_ok = (state_q == S_EXEC) && (st_q == ST_OK);
  assign cnt_dec = cnt_q - 8'd1;
  assign cnt_inc = (cnt_q == '1) ? cnt_q : (cnt_q + 8'd1);
  assign cnt_new = (op_q == OP_ALLOC) ? cnt_dec : cnt_inc;

  assign upd.en    = exec_ok;
  assign upd.head  = (op_q == OP_ALLOC) ? link_rdata : blk_q;
  assign upd.count = cnt_new;

  assign link_we    = exec_ok && (op_q == OP_FREE);
  assign link_waddr = {chunk_q, blk_q};

  // Most recently used chunk
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q     <= '0;
      recent_vld_q <= 1'b0;
    end else if (cfg.init) begin
      recent_q     <= '0;
      recent_vld_q <= 1'b0;
    end else if (exec_ok && op_q == OP_ALLOC) begin
      recent_q     <= chunk_q;
      recent_vld_q <= 1'b1;
    end
  end

  // Sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC:  state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Result beat
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= (state_q == S_EXEC);
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EXEC) begin
      res_st_q    <= st_q;
      res_chunk_q <= exec_ok ? chunk_q : '0;
      res_blk_q   <= exec_ok ? blk_q   : '0;
      res_left_q  <= exec_ok ? cnt_new : '0;
    end
  end

  assign done_o          = done_q;
  assign status_o        = res_st_q;
  assign granted_chunk_o = res_chunk_q;
  assign granted_block_o = res_blk_q;
  assign free_left_o     = res_left_q;

  // Every accepted command yields its result beat, registered from the execute state
  a_result_timing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> !done_o ##1 done_o)
    else $error("result beat not two cycles after accept");

  // Failed commands carry an all-zero payload
  a_fail_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |->
      (granted_chunk_o == '0 && granted_block_o == '0 && free_left_o == '0))
    else $error("failed command with nonzero payload");

  // A successful allocation always pops from a chunk with free blocks
  a_alloc_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (exec_ok && op_q == OP_ALLOC) |-> (cnt_q != '0))
    else $error("allocation from an empty chunk");

endmodule
